>>> hw/rtl/qgc_pkg.sv
// Shared types and constants of the queens greedy crossover block.
// No dependencies; used by the channel interfaces, the cell and the top level.
package qgc_pkg;

  localparam int BOARD_W  = 32;
  localparam int CONF_W   = 5;
  localparam int CONF_MAX = 31;

  // Which board a probe is scored against, and where its exit sum goes.
  typedef enum logic [1:0] {
    PK_MOM = 2'd0,
    PK_DAD = 2'd1,
    PK_NEW = 2'd2,
    PK_OLD = 2'd3
  } probe_kind_t;

  typedef struct packed {
    logic load_in;   // capture parent rows
    logic pick_en;   // seed child from the chosen parent
    logic pick_mom;  // child seeded from mother (other parent is father)
    logic upd_en;    // take the other parent's row into this column
  } cell_ctl_t;

endpackage

>>> hw/rtl/qgc_in_if.sv
// Input channel: valid/ready handshake carrying one pair of parent boards.
// Depends on qgc_pkg.
interface qgc_in_if;
  logic                          valid;
  logic                          ready;
  logic [qgc_pkg::BOARD_W-1:0]   mother_board;
  logic [qgc_pkg::BOARD_W-1:0]   father_board;

  modport source (output valid, output mother_board, output father_board, input ready);
  modport sink   (input valid, input mother_board, input father_board, output ready);
endinterface

>>> hw/rtl/qgc_out_if.sv
// Result channel: valid/ready handshake carrying the child board and its count.
// Depends on qgc_pkg.
interface qgc_out_if;
  logic                          valid;
  logic                          ready;
  logic [qgc_pkg::BOARD_W-1:0]   child_board;
  logic [qgc_pkg::CONF_W-1:0]    child_conflicts;

  modport source (output valid, output child_board, output child_conflicts, input ready);
  modport sink   (input valid, input child_board, input child_conflicts, output ready);
endinterface

>>> hw/rtl/qgc_cell.sv
// One column cell: holds mother, father and child rows of its column and
// adds its conflicts with a passing probe to the running sum. Depends on qgc_pkg.
module qgc_cell #(
  parameter int IDX      = 0,
  parameter int ROW_BITS = 4,
  parameter int COL_W    = 3,
  parameter int SUM_W    = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qgc_pkg::cell_ctl_t        ctl,
  input  logic [ROW_BITS-1:0]       ld_mom,
  input  logic [ROW_BITS-1:0]       ld_dad,
  input  logic                      prb_valid_i,
  input  qgc_pkg::probe_kind_t      prb_kind_i,
  input  logic [COL_W-1:0]          prb_col_i,
  input  logic [ROW_BITS-1:0]       prb_row_i,
  input  logic [SUM_W-1:0]          prb_sum_i,
  output logic                      prb_valid_o,
  output qgc_pkg::probe_kind_t      prb_kind_o,
  output logic [COL_W-1:0]          prb_col_o,
  output logic [ROW_BITS-1:0]       prb_row_o,
  output logic [SUM_W-1:0]          prb_sum_o,
  output logic [ROW_BITS-1:0]       mom_row,
  output logic [ROW_BITS-1:0]       dad_row,
  output logic [ROW_BITS-1:0]       child_row
);

  localparam int DW = ROW_BITS + COL_W;
  localparam logic [COL_W-1:0] MY_COL = COL_W'(IDX);

  logic [ROW_BITS-1:0]  mom_r, dad_r, child_r;
  logic                 pv_r;
  qgc_pkg::probe_kind_t pk_r;
  logic [COL_W-1:0]     pc_r;
  logic [ROW_BITS-1:0]  prow_r;
  logic [SUM_W-1:0]     psum_r;

  logic [ROW_BITS-1:0]  ref_row;
  logic [ROW_BITS-1:0]  rdist;
  logic [COL_W-1:0]     cdist;
  logic                 hit;
  logic [1:0]           add;
  logic [SUM_W-1:0]     sum_nxt;

  always_comb begin
    case (prb_kind_i)
      qgc_pkg::PK_MOM: ref_row = mom_r;
      qgc_pkg::PK_DAD: ref_row = dad_r;
      default:         ref_row = child_r;
    endcase
    rdist = (ref_row > prb_row_i) ? ref_row - prb_row_i : prb_row_i - ref_row;
    cdist = (MY_COL > prb_col_i) ? MY_COL - prb_col_i : prb_col_i - MY_COL;
    hit   = (prb_col_i != MY_COL) && (ref_row != '0) && (prb_row_i != '0);
    add   = 2'd0;
    if (hit) begin
      add = 2'({1'b0, rdist == '0} + {1'b0, DW'(rdist) == DW'(cdist)});
    end
    sum_nxt = prb_sum_i + SUM_W'(add);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      mom_r <= ld_mom;
      dad_r <= ld_dad;
    end
    if (ctl.pick_en) begin
      child_r <= ctl.pick_mom ? mom_r : dad_r;
    end else if (ctl.upd_en) begin
      child_r <= ctl.pick_mom ? dad_r : mom_r;
    end
    pk_r   <= prb_kind_i;
    pc_r   <= prb_col_i;
    prow_r <= prb_row_i;
    psum_r <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= prb_valid_i;
    end
  end

  assign prb_valid_o = pv_r;
  assign prb_kind_o  = pk_r;
  assign prb_col_o   = pc_r;
  assign prb_row_o   = prow_r;
  assign prb_sum_o   = psum_r;
  assign mom_row     = mom_r;
  assign dad_row     = dad_r;
  assign child_row   = child_r;

endmodule

>>> hw/rtl/queens_greedy_crossover.sv
// Queens greedy crossover: sequencer plus a chain of column cells.
// Depends on qgc_pkg, qgc_in_if, qgc_out_if and qgc_cell.
//
// Usage: in_ch carries a pair of parent boards (ROW_BITS-bit row per column,
// column 0 in the low bits, 0 = empty); a transfer happens when valid and
// ready are both high. out_ch returns the child board and its conflict count,
// one result per input, in order.
// A probe (column, row) walks the cell chain one cell per cycle and collects
// its conflicts with every other column.
// Scoring both parents streams 2*COLUMNS probes.
// Each column trial sends two probes and waits for them.
// One pair is processed at a time and in_ch.ready is high only while the
// sequencer is idle, so a new pair is not taken before the last child is
// finished and handed to the output register.
// The result sits in an output register; the next pair is accepted while it
// waits, and a stalled receiver only blocks the block once the next child is
// finished. Reset clears the sequencer, the probe chain and out_ch.valid.
module queens_greedy_crossover #(
  parameter int COLUMNS  = 8,
  parameter int ROW_BITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  qgc_in_if.sink    in_ch,
  qgc_out_if.source out_ch
);

  localparam int PACK_W = COLUMNS * ROW_BITS;
  localparam int EXT_W  = (PACK_W > qgc_pkg::BOARD_W) ? PACK_W : qgc_pkg::BOARD_W;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int SUM_W  = $clog2(2 * COLUMNS - 1);
  localparam int CNT_W  = $clog2(COLUMNS * (COLUMNS - 1) + 1);
  localparam int TOT_W  = CNT_W + 1;
  localparam int AW     = CNT_W + 1;
  localparam int INJ_W  = $clog2(2 * COLUMNS + 1);
  localparam int SAT_W  = (CNT_W > qgc_pkg::CONF_W) ? CNT_W : qgc_pkg::CONF_W;
  localparam logic [INJ_W-1:0] NPROBE = INJ_W'(2 * COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCORE  = 8'b0000_0010,
    S_PICK   = 8'b0000_0100,
    S_TRY    = 8'b0000_1000,
    S_BASE   = 8'b0001_0000,
    S_WAIT   = 8'b0010_0000,
    S_DECIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [INJ_W-1:0]     inj_r, ext_r;
  logic [COL_W-1:0]     col_r;
  logic                 pick_mom_r;
  logic [TOT_W-1:0]     tm_r, tf_r;
  logic [SUM_W-1:0]     new_r, old_r;
  logic [CNT_W-1:0]     cur_r;
  logic                 out_valid_r;
  logic [qgc_pkg::BOARD_W-1:0] out_board_r;
  logic [qgc_pkg::CONF_W-1:0]  out_conf_r;

  logic [EXT_W-1:0]     mom_ext, dad_ext, child_ext;
  logic [PACK_W-1:0]    child_pack;
  logic [ROW_BITS-1:0]  mom_rows   [COLUMNS];
  logic [ROW_BITS-1:0]  dad_rows   [COLUMNS];
  logic [ROW_BITS-1:0]  child_rows [COLUMNS];
  qgc_pkg::cell_ctl_t   ctl        [COLUMNS];

  logic                 pv   [COLUMNS+1];
  qgc_pkg::probe_kind_t pk   [COLUMNS+1];
  logic [COL_W-1:0]     pc   [COLUMNS+1];
  logic [ROW_BITS-1:0]  prow [COLUMNS+1];
  logic [SUM_W-1:0]     psum [COLUMNS+1];

  logic                 accept;
  logic                 out_load;
  logic [COL_W-1:0]     rd_col;
  logic [ROW_BITS-1:0]  mom_sel, dad_sel, child_sel;
  logic [CNT_W-1:0]     cm, cf;
  logic                 pick_mom_now;
  logic                 keep_new;
  logic [AW-1:0]        cur_upd;
  logic [SAT_W-1:0]     cur_sat;

  assign accept   = in_ch.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign mom_ext = EXT_W'(in_ch.mother_board);
  assign dad_ext = EXT_W'(in_ch.father_board);

  assign rd_col    = (state_r == S_SCORE) ? COL_W'(inj_r >> 1) : col_r;
  assign mom_sel   = mom_rows[rd_col];
  assign dad_sel   = dad_rows[rd_col];
  assign child_sel = child_rows[rd_col];

  assign cm           = CNT_W'(tm_r >> 1);
  assign cf           = CNT_W'(tf_r >> 1);
  assign pick_mom_now = (state_r == S_PICK) ? (cm < cf) : pick_mom_r;
  assign keep_new     = new_r <= old_r;
  assign cur_upd      = AW'(cur_r) + AW'(new_r) - AW'(old_r);
  assign cur_sat      = SAT_W'(cur_r);

  // Probe injection into the head of the chain.
  always_comb begin
    pv[0]   = 1'b0;
    pk[0]   = qgc_pkg::PK_MOM;
    pc[0]   = rd_col;
    prow[0] = mom_sel;
    psum[0] = '0;
    unique case (state_r)
      S_SCORE: begin
        pv[0] = inj_r < NPROBE;
        if (inj_r[0]) begin
          pk[0]   = qgc_pkg::PK_DAD;
          prow[0] = dad_sel;
        end
      end
      S_TRY: begin
        pv[0]   = 1'b1;
        pk[0]   = qgc_pkg::PK_NEW;
        prow[0] = pick_mom_r ? dad_sel : mom_sel;
      end
      S_BASE: begin
        pv[0]   = 1'b1;
        pk[0]   = qgc_pkg::PK_OLD;
        prow[0] = child_sel;
      end
      default: begin
        pv[0] = 1'b0;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < COLUMNS; gi++) begin : g_cell
      always_comb begin
        ctl[gi].load_in  = accept;
        ctl[gi].pick_en  = (state_r == S_PICK);
        ctl[gi].pick_mom = pick_mom_now;
        ctl[gi].upd_en   = (state_r == S_DECIDE) && keep_new && (col_r == COL_W'(gi));
      end

      qgc_cell #(
        .IDX      (gi),
        .ROW_BITS (ROW_BITS),
        .COL_W    (COL_W),
        .SUM_W    (SUM_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl[gi]),
        .ld_mom      (mom_ext[gi*ROW_BITS +: ROW_BITS]),
        .ld_dad      (dad_ext[gi*ROW_BITS +: ROW_BITS]),
        .prb_valid_i (pv[gi]),
        .prb_kind_i  (pk[gi]),
        .prb_col_i   (pc[gi]),
        .prb_row_i   (prow[gi]),
        .prb_sum_i   (psum[gi]),
        .prb_valid_o (pv[gi+1]),
        .prb_kind_o  (pk[gi+1]),
        .prb_col_o   (pc[gi+1]),
        .prb_row_o   (prow[gi+1]),
        .prb_sum_o   (psum[gi+1]),
        .mom_row     (mom_rows[gi]),
        .dad_row     (dad_rows[gi]),
        .child_row   (child_rows[gi])
      );

      assign child_pack[gi*ROW_BITS +: ROW_BITS] = child_rows[gi];
    end
  endgenerate

  assign child_ext = EXT_W'(child_pack);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_SCORE;
      S_SCORE:  if (ext_r == NPROBE) state_nxt = S_PICK;
      S_PICK:   state_nxt = S_TRY;
      S_TRY:    state_nxt = S_BASE;
      S_BASE:   state_nxt = S_WAIT;
      S_WAIT:   if (ext_r == INJ_W'(2)) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (col_r == LAST_COL) ? S_DONE : S_TRY;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sequencer counters, probe exit collection and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      inj_r <= '0;
      ext_r <= '0;
      tm_r  <= '0;
      tf_r  <= '0;
    end else begin
      if ((state_r == S_SCORE) && (inj_r < NPROBE)) begin
        inj_r <= inj_r + INJ_W'(1);
      end
      if ((state_r == S_PICK) || (state_r == S_DECIDE)) begin
        ext_r <= '0;
      end else if (pv[COLUMNS]) begin
        ext_r <= ext_r + INJ_W'(1);
      end
      if (pv[COLUMNS]) begin
        case (pk[COLUMNS])
          qgc_pkg::PK_MOM: tm_r  <= tm_r + TOT_W'(psum[COLUMNS]);
          qgc_pkg::PK_DAD: tf_r  <= tf_r + TOT_W'(psum[COLUMNS]);
          qgc_pkg::PK_NEW: new_r <= psum[COLUMNS];
          default:         old_r <= psum[COLUMNS];
        endcase
      end
    end
    if (state_r == S_PICK) begin
      pick_mom_r <= pick_mom_now;
      cur_r      <= pick_mom_now ? cm : cf;
      col_r      <= '0;
    end
    if (state_r == S_DECIDE) begin
      if (keep_new) begin
        cur_r <= CNT_W'(cur_upd);
      end
      col_r <= col_r + COL_W'(1);
    end
    if (out_load) begin
      out_board_r <= child_ext[qgc_pkg::BOARD_W-1:0];
      out_conf_r  <= (cur_sat > SAT_W'(qgc_pkg::CONF_MAX)) ?
                     qgc_pkg::CONF_W'(qgc_pkg::CONF_MAX) : cur_sat[qgc_pkg::CONF_W-1:0];
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.child_board     = out_board_r;
  assign out_ch.child_conflicts = out_conf_r;

endmodule
